// ----- src/ewrd_pkg.sv -----
`default_nettype none
package ewrd_pkg;
  localparam int ALIGN_SHIFT = 6;
  localparam int WEIGHT_BITS = 8;
  localparam int OFF_W = 49;

  localparam logic [2:0] CFG_RANK_INDEX = 3'd0;
  localparam logic [2:0] CFG_RANK_COUNT = 3'd1;
  localparam logic [2:0] CFG_EPR        = 3'd2;
  localparam logic [2:0] CFG_WORKER     = 3'd3;
  localparam logic [2:0] CFG_WEIGHTS    = 3'd4;
  localparam logic [2:0] CFG_GATE       = 3'd5;
  localparam logic [2:0] CFG_UP         = 3'd6;
  localparam logic [2:0] CFG_DOWN       = 3'd7;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CONFIG = 2'd1;
  localparam logic [1:0] ERR_EXPERT = 2'd2;
  localparam logic [1:0] ERR_LOCAL  = 2'd3;

  typedef struct packed {
    logic start;
    logic div_start;
    logic mul_start;
    logic [1:0] proj;
    logic capture;
    logic emit_desc;
    logic emit_status;
    logic last;
    logic set_err;
    logic [1:0] err_code;
  } ewrd_cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic negative;
    logic too_large;
    logic div_done;
    logic is_local;
    logic mul_done;
    logic len_zero;
  } ewrd_stat_t;
endpackage
`default_nettype wire

// ----- src/ewrd_if.sv -----
`default_nettype none
interface ewrd_in_if;
  logic valid;
  logic ready;
  logic [15:0] plan_slot;
  logic signed [31:0] expert_id;
  modport source (output valid, plan_slot, expert_id, input ready);
  modport sink (input valid, plan_slot, expert_id, output ready);
endinterface

interface ewrd_out_if;
  logic valid;
  logic ready;
  logic issue;
  logic [9:0] peer;
  logic [1:0] projection;
  logic [48:0] source_offset;
  logic [48:0] dest_offset;
  logic [31:0] length;
  logic [1:0] status;
  logic last;
  modport source (output valid, issue, peer, projection, source_offset, dest_offset,
                  length, status, last, input ready);
  modport sink (input valid, issue, peer, projection, source_offset, dest_offset,
                length, status, last, output ready);
endinterface

interface ewrd_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/ewrd_ctrl.sv -----
`default_nettype none
module ewrd_ctrl
  import ewrd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire ewrd_stat_t stat,
  output ewrd_cmd_t cmd,
  output logic in_ready
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_WAITM = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_STAT  = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] proj, proj_next;
  logic any, any_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    proj_next = proj;
    any_next = any;
    cmd = '0;
    cmd.proj = proj;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.start = 1'b1;
          state_next = S_CHECK;
          proj_next = 2'd0;
          any_next = 1'b0;
        end
      end
      S_CHECK: begin
        if (stat.cfg_bad) begin
          cmd.set_err = 1'b1;
          cmd.err_code = ERR_CONFIG;
          state_next = S_STAT;
        end else if (stat.negative) begin
          state_next = S_STAT;
        end else if (stat.too_large) begin
          cmd.set_err = 1'b1;
          cmd.err_code = ERR_EXPERT;
          state_next = S_STAT;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (stat.is_local) begin
            cmd.set_err = 1'b1;
            cmd.err_code = ERR_LOCAL;
            state_next = S_STAT;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next = S_WAITM;
      end
      S_WAITM: begin
        if (stat.mul_done) begin
          // a held descriptor goes out once a later one exists, or at the end through the flush state
          if (!stat.len_zero && any) begin
            state_next = S_EMIT;
          end else begin
            if (!stat.len_zero) begin
              cmd.capture = 1'b1;
              any_next = 1'b1;
            end
            if (proj == 2'd2) begin
              state_next = (any || !stat.len_zero) ? S_FLUSH : S_STAT;
            end else begin
              proj_next = proj + 2'd1;
              state_next = S_MUL;
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit_desc = 1'b1;
          cmd.capture = 1'b1;
          if (proj == 2'd2) begin
            state_next = S_FLUSH;
          end else begin
            proj_next = proj + 2'd1;
            state_next = S_MUL;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          cmd.emit_desc = 1'b1;
          cmd.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STAT: begin
        if (out_free) begin
          cmd.emit_status = 1'b1;
          cmd.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      proj <= 2'd0;
      any <= 1'b0;
    end else begin
      state <= state_next;
      proj <= proj_next;
      any <= any_next;
    end
  end

  a_proj_range: assert property (@(posedge clk) disable iff (rst) proj != 2'd3)
    else $error("projection counter out of range");
  a_emit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_desc && cmd.emit_status)) else $error("two emits at once");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == S_CHECK) else $error("start did not advance");
endmodule
`default_nettype wire

// ----- src/ewrd_dp.sv -----
`default_nettype none
module ewrd_dp
  import ewrd_pkg::*;
#(
  parameter int WORKERS = 8,
  parameter int MAX_RANKS = 1024
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire ewrd_cmd_t cmd,
  output ewrd_stat_t stat,
  input  wire logic [15:0] in_slot,
  input  wire logic [31:0] in_id,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [63:0] cfg_data,
  output logic o_issue,
  output logic [9:0] o_peer,
  output logic [1:0] o_proj,
  output logic [48:0] o_src,
  output logic [48:0] o_dst,
  output logic [31:0] o_len,
  output logic [1:0] o_status
);
  logic [9:0]  rank_index;
  logic [10:0] rank_count;
  logic [15:0] epr;
  logic [2:0]  worker_index;
  logic [63:0] weights;
  logic [31:0] row_bytes [3];
  logic [1:0]  first_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_index <= '0;
      rank_count <= 11'd1;
      epr <= 16'd1;
      worker_index <= '0;
      weights <= 64'h0101010101010101;
      row_bytes[0] <= 32'd64;
      row_bytes[1] <= 32'd64;
      row_bytes[2] <= 32'd64;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RANK_INDEX: rank_index <= cfg_data[9:0];
        CFG_RANK_COUNT: rank_count <= cfg_data[10:0];
        CFG_EPR:        epr <= cfg_data[15:0];
        CFG_WORKER:     worker_index <= cfg_data[2:0];
        CFG_WEIGHTS:    weights <= cfg_data;
        CFG_GATE:       row_bytes[0] <= cfg_data[31:0];
        CFG_UP:         row_bytes[1] <= cfg_data[31:0];
        CFG_DOWN:       row_bytes[2] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // weight sums over the WORKERS narrow lanes of 8 bits each
  logic [10:0] total, bw, ew;
  logic weight_zero;
  always_comb begin
    total = '0;
    bw = '0;
    ew = '0;
    weight_zero = 1'b0;
    for (int w = 0; w < WORKERS; w++) begin
      total = total + 11'(weights[w*WEIGHT_BITS +: WEIGHT_BITS]);
      if (3'(w) < worker_index) bw = bw + 11'(weights[w*WEIGHT_BITS +: WEIGHT_BITS]);
      if (3'(w) <= worker_index) ew = ew + 11'(weights[w*WEIGHT_BITS +: WEIGHT_BITS]);
      if (weights[w*WEIGHT_BITS +: WEIGHT_BITS] == '0) weight_zero = 1'b1;
    end
  end

  logic cfg_bad_c;
  assign cfg_bad_c = (row_bytes[0] == '0) || (row_bytes[1] == '0) || (row_bytes[2] == '0)
    || (rank_count == '0) || (32'(rank_count) > 32'(MAX_RANKS))
    || (11'(rank_index) >= rank_count) || (epr == '0)
    || (32'(worker_index) >= 32'(WORKERS)) || weight_zero;

  logic [15:0] slot;
  logic [31:0] id;
  logic [26:0] limit;
  logic cfg_bad_r;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      slot <= in_slot;
      id <= in_id;
    end
    limit <= epr * rank_count;
    cfg_bad_r <= cfg_bad_c;
  end
  assign stat.cfg_bad = cfg_bad_r;
  assign stat.negative = id[31];
  assign stat.too_large = {1'b0, id[30:0]} >= 32'(limit);

  // restoring divider, one quotient bit per cycle
  logic [31:0] dq;
  logic [15:0] drem;
  logic [5:0]  dcnt;
  logic        dbusy;
  logic [16:0] dtrial;
  assign dtrial = {drem, dq[31]} - {1'b0, epr};
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dbusy <= 1'b1;
      dcnt <= 6'd32;
      dq <= id;
      drem <= '0;
    end else if (dbusy) begin
      if (dtrial[16]) begin
        drem <= {drem[14:0], dq[31]};
        dq <= {dq[30:0], 1'b0};
      end else begin
        drem <= dtrial[15:0];
        dq <= {dq[30:0], 1'b1};
      end
      dcnt <= dcnt - 6'd1;
      if (dcnt == 6'd1) dbusy <= 1'b0;
    end
  end
  // quotient fits 10 bits since id < limit
  logic div_fin;
  always_ff @(posedge clk) begin
    if (rst) div_fin <= 1'b0;
    else div_fin <= dbusy && dcnt == 6'd1;
  end
  assign stat.div_done = div_fin;
  logic [9:0] owner;
  assign owner = dq[9:0];
  assign stat.is_local = owner == rank_index;

  // per-projection slice: small multiply then divide by total
  logic [31:0] row;
  assign row = row_bytes[cmd.proj];
  logic [42:0] pb, pe;
  logic [31:0] qb, qe;
  logic [10:0] rb, re;
  logic [5:0]  mcnt;
  logic        mbusy, mdone;
  logic [11:0] tb, te;
  assign tb = {rb, pb[42]} - {1'b0, total};
  assign te = {re, pe[42]} - {1'b0, total};
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mcnt <= '0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        pb <= row * bw;
        pe <= row * ew;
        rb <= '0;
        re <= '0;
        mbusy <= 1'b1;
        mcnt <= 6'd43;
      end else if (mbusy) begin
        if (tb[11]) begin
          rb <= {rb[9:0], pb[42]};
          pb <= {pb[41:0], 1'b0};
        end else begin
          rb <= tb[10:0];
          pb <= {pb[41:0], 1'b1};
        end
        if (te[11]) begin
          re <= {re[9:0], pe[42]};
          pe <= {pe[41:0], 1'b0};
        end else begin
          re <= te[10:0];
          pe <= {pe[41:0], 1'b1};
        end
        mcnt <= mcnt - 6'd1;
        if (mcnt == 6'd1) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
      end
    end
  end
  // quotient < row, fits 32 bits
  assign qb = {pb[31:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}};
  assign qe = (32'(worker_index) + 32'd1 == 32'(WORKERS)) ? row
            : {pe[31:ALIGN_SHIFT], {ALIGN_SHIFT{1'b0}}};
  logic [31:0] len;
  assign len = qe - qb;
  assign stat.mul_done = mdone;
  assign stat.len_zero = len == '0;

  logic [15:0] local_e;
  assign local_e = drem;

  // hold one sliced projection until it is known whether it is the last one
  logic [1:0]  pend_proj;
  logic [31:0] pend_qb, pend_len;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_proj <= cmd.proj;
      pend_qb <= qb;
      pend_len <= len;
    end
  end
  logic [31:0] pend_row;
  assign pend_row = row_bytes[pend_proj];

  // output products: a 16x32 and a 17x32 multiply, registered on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      first_error <= ERR_NONE;
    end else if (cmd.set_err && first_error == ERR_NONE) begin
      first_error <= cmd.err_code;
    end
  end

  logic [1:0] err_now;
  assign err_now = (cmd.set_err && first_error == ERR_NONE) ? cmd.err_code : first_error;

  always_ff @(posedge clk) begin
    if (cmd.emit_desc) begin
      o_issue <= 1'b1;
      o_peer <= owner;
      o_proj <= pend_proj;
      o_src <= OFF_W'(local_e) * OFF_W'(pend_row) + OFF_W'(pend_qb);
      o_dst <= (OFF_W'(epr) + OFF_W'(slot)) * OFF_W'(pend_row) + OFF_W'(pend_qb);
      o_len <= pend_len;
      o_status <= first_error;
    end else if (cmd.emit_status) begin
      o_issue <= 1'b0;
      o_peer <= '0;
      o_proj <= '0;
      o_src <= '0;
      o_dst <= '0;
      o_len <= '0;
      o_status <= err_now;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    first_error != ERR_NONE |=> first_error == $past(first_error))
    else $error("first error changed");
  a_div_excl: assert property (@(posedge clk) disable iff (rst)
    !(dbusy && mbusy)) else $error("divider and slicer both busy");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !dbusy) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// ----- src/expert_weight_read_descriptor_gen.sv -----
`default_nettype none
// Channel   Dir  Payload
// in_ch     in   plan_slot, expert_id
// out_ch    out  issue, peer, projection, source_offset, dest_offset, length,
//                status, last
// cfg_ch    in   index, data
// One item at a time: accept, check, the bit-serial owner divide, a bit-serial slice
// divide for each projection, and the emitted results.
// A skipped or rejected item goes from the check straight to its status; a local
// owner goes to its status after the owner divide.
// rst is synchronous; configuration returns to its defaults, status clears.
// A stalled output holds the controller in its emit states.
module expert_weight_read_descriptor_gen
  import ewrd_pkg::*;
#(
  parameter int WORKERS = 8,
  parameter int MAX_RANKS = 1024
)
(
  input wire logic clk,
  input wire logic rst,
  ewrd_in_if.sink in_ch,
  ewrd_out_if.source out_ch,
  ewrd_cfg_if.sink cfg_ch
);
  ewrd_cmd_t cmd;
  ewrd_stat_t stat;
  logic in_ready, out_free, ovalid, olast;
  logic fire;

  assign fire = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free = !ovalid || out_ch.ready;

  ewrd_ctrl u_ctrl (
    .clk, .rst, .in_fire(fire), .out_free, .stat, .cmd, .in_ready
  );

  ewrd_dp #(.WORKERS(WORKERS), .MAX_RANKS(MAX_RANKS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_slot(in_ch.plan_slot), .in_id(in_ch.expert_id),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .o_issue(out_ch.issue), .o_peer(out_ch.peer), .o_proj(out_ch.projection),
    .o_src(out_ch.source_offset), .o_dst(out_ch.dest_offset),
    .o_len(out_ch.length), .o_status(out_ch.status)
  );

  // last comes from the controller: status result or the final held descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.emit_desc || cmd.emit_status) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_desc || cmd.emit_status) olast <= cmd.last;
  end
  assign out_ch.valid = ovalid;
  assign out_ch.last = olast;
endmodule
`default_nettype wire
